/* hw/rtl/nsd_pkg.sv */
package nsd_pkg;

   // default sizes of the length field
   localparam int unsigned MAX_LEN_DIGITS_DEF = 10;
   localparam int unsigned LENGTH_BITS_DEF    = 24;

   // configuration register
   localparam int unsigned MAX_LEN_W   = 24;
   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 24'd65535;

   // framing characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      ST_NONE       = 3'd0,
      ST_COMPLETE   = 3'd1,
      ST_TOO_LONG   = 3'd2,
      ST_BAD_DIGIT  = 3'd3,
      ST_BAD_LENGTH = 3'd4,
      ST_NO_COMMA   = 3'd5
   } nsd_status_type;

   typedef struct packed {
      logic [7:0]     payload_byte;
      logic           payload_valid;
      logic           frame_last;
      nsd_status_type status;
   } nsd_result_type;

endpackage

/* hw/rtl/nsd_parse.sv */
module nsd_parse
   import nsd_pkg::*;
#(
   parameter int unsigned MAX_LEN_DIGITS = MAX_LEN_DIGITS_DEF,
   parameter int unsigned LENGTH_BITS    = LENGTH_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  logic [MAX_LEN_W-1:0] max_len,
   output nsd_result_type       result
);

   localparam int unsigned PROD_W = LENGTH_BITS + 4;
   localparam int unsigned CMP_W  = (LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W;

   typedef enum logic [1:0] {
      PH_LENGTH  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_COMMA   = 2'd2
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [3:0]              digit_count_ff, digit_count_in;
   logic [LENGTH_BITS-1:0]  length_accum_ff, length_accum_in;
   logic [LENGTH_BITS-1:0]  payload_count_ff, payload_count_in;
   nsd_result_type          result_ff, result_in;

   logic [PROD_W-1:0]       accum_x10;
   logic [LENGTH_BITS-1:0]  count_inc;
   logic                    is_digit;
   logic                    too_big;

   // digits '0'..'9' sit at 0x30..0x39, so the low nibble is the value
   assign accum_x10 = (PROD_W'(length_accum_ff) << 3) + (PROD_W'(length_accum_ff) << 1)
                    + PROD_W'(rx_byte[3:0]);
   assign count_inc = payload_count_ff + 1'b1;
   assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign too_big   = CMP_W'(length_accum_ff) > CMP_W'(max_len);

   always_comb begin
      phase_in         = phase_ff;
      digit_count_in   = digit_count_ff;
      length_accum_in  = length_accum_ff;
      payload_count_in = payload_count_ff;
      result_in        = '{payload_byte: 8'd0, payload_valid: 1'b0,
                           frame_last: 1'b0, status: ST_NONE};

      unique case (phase_ff)
         PH_PAYLOAD: begin
            result_in.payload_byte  = rx_byte;
            result_in.payload_valid = 1'b1;
            payload_count_in        = count_inc;
            if (count_inc >= length_accum_ff) begin
               phase_in = PH_COMMA;
            end
         end
         PH_COMMA: begin
            if (rx_byte == CHAR_COMMA) begin
               result_in.status     = ST_COMPLETE;
               result_in.frame_last = 1'b1;
            end else begin
               result_in.status = ST_NO_COMMA;
            end
            phase_in         = PH_LENGTH;
            digit_count_in   = '0;
            length_accum_in  = '0;
            payload_count_in = '0;
         end
         default: begin
            // length phase; the unused code behaves the same
            phase_in = PH_LENGTH;
            if (rx_byte == CHAR_COLON) begin
               digit_count_in   = '0;
               payload_count_in = '0;
               if ((digit_count_ff == 4'd0) || too_big) begin
                  result_in.status = ST_BAD_LENGTH;
                  length_accum_in  = '0;
               end else if (length_accum_ff == '0) begin
                  phase_in = PH_COMMA;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else if (is_digit) begin
               if (digit_count_ff >= 4'(MAX_LEN_DIGITS)) begin
                  result_in.status = ST_TOO_LONG;
                  digit_count_in   = '0;
                  length_accum_in  = '0;
                  payload_count_in = '0;
               end else begin
                  // saturate at all ones
                  length_accum_in = (|accum_x10[PROD_W-1:LENGTH_BITS])
                                  ? '1 : accum_x10[LENGTH_BITS-1:0];
                  digit_count_in  = digit_count_ff + 4'd1;
               end
            end else begin
               result_in.status = ST_BAD_DIGIT;
               digit_count_in   = '0;
               length_accum_in  = '0;
               payload_count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LENGTH;
         digit_count_ff   <= '0;
         length_accum_ff  <= '0;
         payload_count_ff <= '0;
         result_ff        <= '{payload_byte: 8'd0, payload_valid: 1'b0,
                               frame_last: 1'b0, status: ST_NONE};
      end else if (step) begin
         phase_ff         <= phase_in;
         digit_count_ff   <= digit_count_in;
         length_accum_ff  <= length_accum_in;
         payload_count_ff <= payload_count_in;
         result_ff        <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* hw/rtl/netstring_deframer_core.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_rx_byte
// rsp_      out        rsp_valid/rsp_ready  rsp_payload_byte, rsp_payload_valid,
//                                           rsp_frame_last, rsp_status
// csr_      in         csr_we               csr_wdata (max payload length)
//
// One transaction in, one transaction out. Throughput is one byte per cycle
// while rsp_ready is high; a byte passes the input register, then the parser
// step into the result register. The parser state update, a shift-add multiply
// by ten and a compare, is the path that sets the clock. Synchronous reset
// clears the parser to the length phase and the limit to 65535. A stalled
// result holds both registers; the input register still takes a byte if empty.
module netstring_deframer_core
   import nsd_pkg::*;
#(
   parameter int unsigned MAX_LEN_DIGITS = MAX_LEN_DIGITS_DEF,
   parameter int unsigned LENGTH_BITS    = LENGTH_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_payload_valid,
   output logic                 rsp_frame_last,
   output logic [2:0]           rsp_status,
   input  logic                 csr_we,
   input  logic [MAX_LEN_W-1:0] csr_wdata
);

   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           rx_byte_ff;
   logic                 out_vld_ff, out_vld_in;
   logic [MAX_LEN_W-1:0] max_len_ff;
   logic                 advance;
   logic                 step;
   nsd_result_type       result;

   assign advance    = !out_vld_ff || rsp_ready;
   assign step       = in_vld_ff && advance;
   assign req_ready  = !in_vld_ff || advance;
   assign in_vld_in  = req_ready ? req_valid : in_vld_ff;
   assign out_vld_in = advance ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rx_byte_ff <= req_rx_byte;
      end
   end

   nsd_parse #(
      .MAX_LEN_DIGITS (MAX_LEN_DIGITS),
      .LENGTH_BITS    (LENGTH_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (rx_byte_ff),
      .max_len (max_len_ff),
      .result  (result)
   );

   assign rsp_valid         = out_vld_ff;
   assign rsp_payload_byte  = result.payload_byte;
   assign rsp_payload_valid = result.payload_valid;
   assign rsp_frame_last    = result.frame_last;
   assign rsp_status        = result.status;

   // a frame end is always reported as complete
   a_last_complete : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_status == ST_COMPLETE)
      else $error("frame_last without complete status");

   // payload bytes carry no status
   a_payload_no_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_status == ST_NONE && !rsp_frame_last)
      else $error("payload byte with status");

   // non-payload results carry a zero data byte
   a_data_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'd0)
      else $error("data byte set outside payload");

   // a buffered byte moves to the result register when the output is free
   a_advance : assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("buffered transaction not advanced");

endmodule
